// File: sv/rcf_pkg.sv
// Shared types, codes and helpers for the RTS/CTS receiver.
`default_nettype none
package rcf_pkg;

  localparam int TIME_BITS_DEF = 31;
  localparam int DUR_W         = 16;
  localparam int CFG_IDX_W     = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_DUR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RTS_DUR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTS_DUR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIFS_DUR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_DUR     = 3'd4;

  // Sender and channel codes
  localparam logic [2:0] SENDER_RTS   = 3'd4;
  localparam logic [1:0] CHAN_IDLE    = 2'd0;
  localparam logic [1:0] CHAN_CLEAN   = 2'd1;
  localparam logic [1:0] CHAN_COLLIDE = 2'd2;

  // Channel action codes (2-bit two's complement)
  localparam logic signed [1:0] ACT_NONE = 2'sb00;
  localparam logic signed [1:0] ACT_SEND = 2'sb01;
  localparam logic signed [1:0] ACT_FREE = 2'sb11;

  // Phase codes as seen on the result channel
  localparam logic [2:0] PH_CODE_WAIT    = 3'd0;
  localparam logic [2:0] PH_CODE_RTS     = 3'd1;
  localparam logic [2:0] PH_CODE_CTS     = 3'd2;
  localparam logic [2:0] PH_CODE_RECEIVE = 3'd3;
  localparam logic [2:0] PH_CODE_SIFS    = 3'd4;
  localparam logic [2:0] PH_CODE_ACK     = 3'd5;

  typedef enum logic [5:0] {
    PH_WAIT    = 6'b000001,
    PH_RTS     = 6'b000010,
    PH_CTS     = 6'b000100,
    PH_RECEIVE = 6'b001000,
    PH_SIFS    = 6'b010000,
    PH_ACK     = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [15:0] receive_dur;
    logic [7:0]  rts_dur;
    logic [7:0]  cts_dur;
    logic [7:0]  sifs_dur;
    logic [7:0]  ack_dur;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    phase_t before_sifs;
    logic   message_ok;
  } ctl_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_WAIT:    code = PH_CODE_WAIT;
      PH_RTS:     code = PH_CODE_RTS;
      PH_CTS:     code = PH_CODE_CTS;
      PH_RECEIVE: code = PH_CODE_RECEIVE;
      PH_SIFS:    code = PH_CODE_SIFS;
      PH_ACK:     code = PH_CODE_ACK;
      default:    code = PH_CODE_WAIT;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// File: sv/rcf_if.sv
// Request and result channel interfaces of the RTS/CTS receiver.
`default_nettype none
interface rcf_in_if #(
  parameter int TIME_BITS = rcf_pkg::TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] current_time;
  logic [2:0]           sender_status;
  logic [1:0]           channel_users;

  modport source (output valid, current_time, sender_status, channel_users, input ready);
  modport sink   (input valid, current_time, sender_status, channel_users, output ready);
endinterface

interface rcf_out_if #(
  parameter int TIME_BITS = rcf_pkg::TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [1:0]    channel_action;
  logic [2:0]           phase;
  logic [TIME_BITS-1:0] next_event;

  modport source (output valid, channel_action, phase, next_event, input ready);
  modport sink   (input valid, channel_action, phase, next_event, output ready);
endinterface
`default_nettype wire

// File: sv/rts_cts_receiver_fsm.sv
// Top level of the RTS/CTS handshake receiver.
// The receiver takes one request per simulation time point (current time,
// sender phase, number of transmitters on the channel) and returns one result
// for it: the channel action (+1 send CTS or ACK, -1 free the channel, 0
// nothing), the phase after the step (0 wait, 1 rts, 2 cts, 3 receive, 4 sifs,
// 5 ack) and the pending deadline, all ones meaning no pending event. A phase other
// than wait ends only when the request's time equals the stored deadline; deadlines
// saturate one below the no-event value. Throughput is one request per clock while
// the result channel is not stalled: a request lands in an input register, and the
// state update (one duration mux, one saturating adder, one equality compare) then
// writes the state and the result register together. That state loop sets the rate.
// A stalled result holds the result register, and the input register keeps taking
// requests until it too is full. Write the duration registers only while no request is
// in flight; reset loads receive 100, rts 2, cts 2, sifs 1, ack 2.
`default_nettype none
module rts_cts_receiver_fsm #(
  parameter int TIME_BITS = rcf_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rcf_in_if.sink                             in_ch,
  rcf_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rcf_pkg::DUR_W-1:0]     cfg_data
);
  import rcf_pkg::*;

  localparam logic [TIME_BITS-1:0] NO_EVENT = {TIME_BITS{1'b1}};

  cfg_t cfg;

  // Input register
  logic                 s1_valid_r;
  logic [TIME_BITS-1:0] s1_time_r;
  logic [2:0]           s1_sender_r;
  logic [1:0]           s1_chan_r;

  // Receiver state
  ctl_t                 ctl_r;
  ctl_t                 ctl_nxt;
  logic [TIME_BITS-1:0] deadline_r;
  logic [TIME_BITS-1:0] deadline_nxt;

  // Result register
  logic                 out_valid_r;
  logic signed [1:0]    out_action_r;
  logic [2:0]           out_phase_r;
  logic [TIME_BITS-1:0] out_event_r;

  logic signed [1:0]    step_action;
  logic                 out_free;
  logic                 step_fire;
  logic                 in_take;

  rcf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcf_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .ctl           (ctl_r),
    .deadline      (deadline_r),
    .cfg           (cfg),
    .cur_time      (s1_time_r),
    .sender_status (s1_sender_r),
    .channel_users (s1_chan_r),
    .ctl_nxt       (ctl_nxt),
    .deadline_nxt  (deadline_nxt),
    .action        (step_action)
  );

  // Advance the held request when the result register is empty or draining
  assign out_free  = !out_valid_r || out_ch.ready;
  assign step_fire = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || step_fire;
  assign in_take   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_time_r   <= in_ch.current_time;
      s1_sender_r <= in_ch.sender_status;
      s1_chan_r   <= in_ch.channel_users;
    end
  end

  // Commit the step: state and result move together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase       <= PH_WAIT;
      ctl_r.before_sifs <= PH_WAIT;
      ctl_r.message_ok  <= 1'b0;
      deadline_r        <= NO_EVENT;
    end else if (step_fire) begin
      ctl_r      <= ctl_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_action_r <= step_action;
      out_phase_r  <= phase_code(ctl_nxt.phase);
      out_event_r  <= deadline_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.channel_action = out_action_r;
  assign out_ch.phase          = out_phase_r;
  assign out_ch.next_event     = out_event_r;

  // Wait always has no pending event; every other phase has a real deadline
  a_wait_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.phase == PH_WAIT) |-> (deadline_r == NO_EVENT))
    else $error("wait phase with a pending deadline");

  a_busy_has_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.phase != PH_WAIT) |-> (deadline_r != NO_EVENT))
    else $error("active phase without a deadline");

  // A send request only comes with entry to cts or ack
  a_send_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && step_action == ACT_SEND) |=> (ctl_r.phase == PH_CTS || ctl_r.phase == PH_ACK))
    else $error("send action outside cts/ack entry");

  // A held request waits while the result register is stalled
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_time_r) && $stable(ctl_r)))
    else $error("request or state moved during a result stall");

endmodule
`default_nettype wire

// File: sv/rcf_cfg_regs.sv
// Duration registers of the RTS/CTS receiver, written through the config port.
`default_nettype none
module rcf_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rcf_pkg::DUR_W-1:0]     cfg_data,
  output rcf_pkg::cfg_t                      cfg
);
  import rcf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_RECEIVE_DUR: cfg_nxt.receive_dur = cfg_data;
        REG_RTS_DUR:     cfg_nxt.rts_dur     = cfg_data[7:0];
        REG_CTS_DUR:     cfg_nxt.cts_dur     = cfg_data[7:0];
        REG_SIFS_DUR:    cfg_nxt.sifs_dur    = cfg_data[7:0];
        REG_ACK_DUR:     cfg_nxt.ack_dur     = cfg_data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.receive_dur <= 16'd100;
      cfg_r.rts_dur     <= 8'd2;
      cfg_r.cts_dur     <= 8'd2;
      cfg_r.sifs_dur    <= 8'd1;
      cfg_r.ack_dur     <= 8'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: sv/rcf_step.sv
// Next-state logic of the RTS/CTS receiver: one time step per evaluation.
`default_nettype none
module rcf_step #(
  parameter int TIME_BITS = rcf_pkg::TIME_BITS_DEF
) (
  input  wire rcf_pkg::ctl_t        ctl,
  input  wire logic [TIME_BITS-1:0] deadline,
  input  wire rcf_pkg::cfg_t        cfg,
  input  wire logic [TIME_BITS-1:0] cur_time,
  input  wire logic [2:0]           sender_status,
  input  wire logic [1:0]           channel_users,
  output rcf_pkg::ctl_t            ctl_nxt,
  output logic [TIME_BITS-1:0]      deadline_nxt,
  output logic signed [1:0]         action
);
  import rcf_pkg::*;

  localparam int SUM_W = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;
  localparam logic [TIME_BITS-1:0] NO_EVENT = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] MAX_DL   = {{(TIME_BITS-1){1'b1}}, 1'b0};

  logic [DUR_W-1:0]     dur_sel;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] later;
  logic                 due;

  // Pick the duration of whatever phase this step may enter
  always_comb begin
    dur_sel = '0;
    case (ctl.phase)
      PH_WAIT:                    dur_sel = {8'd0, cfg.rts_dur};
      PH_RTS, PH_CTS, PH_RECEIVE: dur_sel = {8'd0, cfg.sifs_dur};
      PH_SIFS: begin
        case (ctl.before_sifs)
          PH_RTS:     dur_sel = {8'd0, cfg.cts_dur};
          PH_CTS:     dur_sel = cfg.receive_dur;
          PH_RECEIVE: dur_sel = {8'd0, cfg.ack_dur};
          default:    dur_sel = '0;
        endcase
      end
      default: dur_sel = '0;
    endcase
  end

  // Saturate below the no-event value
  always_comb begin
    sum = {{(SUM_W-TIME_BITS){1'b0}}, cur_time} + {{(SUM_W-DUR_W){1'b0}}, dur_sel};
    if (sum > {{(SUM_W-TIME_BITS){1'b0}}, MAX_DL}) begin
      later = MAX_DL;
    end else begin
      later = sum[TIME_BITS-1:0];
    end
  end

  assign due = (cur_time == deadline);

  always_comb begin
    ctl_nxt      = ctl;
    deadline_nxt = deadline;
    action       = ACT_NONE;
    case (ctl.phase)
      PH_WAIT: begin
        ctl_nxt.message_ok = 1'b1;
        if (channel_users != CHAN_IDLE && sender_status == SENDER_RTS) begin
          ctl_nxt.phase = PH_RTS;
          deadline_nxt  = later;
          if (channel_users == CHAN_COLLIDE) begin
            ctl_nxt.message_ok = 1'b0;
          end
        end
      end
      PH_RTS: begin
        if (channel_users != CHAN_CLEAN) begin
          ctl_nxt.message_ok = 1'b0;
        end
        if (due) begin
          ctl_nxt.before_sifs = PH_RTS;
          ctl_nxt.phase       = PH_SIFS;
          deadline_nxt        = later;
        end
      end
      PH_CTS: begin
        if (due) begin
          ctl_nxt.before_sifs = PH_CTS;
          if (ctl.message_ok) begin
            ctl_nxt.phase = PH_SIFS;
            deadline_nxt  = later;
          end else begin
            ctl_nxt.phase = PH_WAIT;
            deadline_nxt  = NO_EVENT;
          end
        end
      end
      PH_RECEIVE: begin
        ctl_nxt.before_sifs = PH_RECEIVE;
        if (channel_users != CHAN_CLEAN) begin
          ctl_nxt.message_ok = 1'b0;
        end
        if (due) begin
          ctl_nxt.phase = PH_SIFS;
          deadline_nxt  = later;
        end
      end
      PH_SIFS: begin
        if (due) begin
          case (ctl.before_sifs)
            PH_RTS: begin
              ctl_nxt.phase = PH_CTS;
              deadline_nxt  = later;
              if (ctl.message_ok) begin
                action = ACT_SEND;
              end
            end
            PH_CTS: begin
              ctl_nxt.phase      = PH_RECEIVE;
              ctl_nxt.message_ok = 1'b1;
              deadline_nxt       = later;
              action             = ACT_FREE;
            end
            PH_RECEIVE: begin
              ctl_nxt.phase = PH_ACK;
              deadline_nxt  = later;
              if (ctl.message_ok) begin
                action = ACT_SEND;
              end
            end
            default: ctl_nxt = ctl;
          endcase
        end
      end
      PH_ACK: begin
        if (due) begin
          ctl_nxt.phase = PH_WAIT;
          deadline_nxt  = NO_EVENT;
          if (ctl.message_ok) begin
            action = ACT_FREE;
          end
        end
      end
      default: ctl_nxt = ctl;
    endcase
  end

endmodule
`default_nettype wire
